/* hw/rtl/spc_pkg.sv */
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the sheet pulse counter.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_EMPTY_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_STOP_TIMEOUT    = 2'd1;
    localparam logic [1:0] REG_SLOW_TIMEOUT    = 2'd2;

    // Register reset values
    localparam logic [7:0]  EMPTY_THRESHOLD_RST = 8'd2;
    localparam logic [31:0] STOP_TIMEOUT_RST    = 32'd1000000;
    localparam logic [31:0] SLOW_TIMEOUT_RST    = 32'd1500000;

    // Event opcodes
    localparam logic [1:0] OP_TOOTH = 2'd0;
    localparam logic [1:0] OP_PULSE = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Machine state codes as reported on the result channel
    localparam logic [1:0] MS_CODE_RUN   = 2'd0;
    localparam logic [1:0] MS_CODE_EMPTY = 2'd1;
    localparam logic [1:0] MS_CODE_STOP  = 2'd2;

    localparam logic [7:0] PULSE_MAX = 8'hFF;

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_EMPTY = 3'b010,
        ST_STOP  = 3'b100
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        edge_level;
        logic [31:0] time_us;
    } spc_in_t;

    typedef struct packed {
        logic [31:0] sheet_count;
        logic [1:0]  machine_state;
    } spc_out_t;

    typedef struct packed {
        logic [7:0]  empty_threshold;
        logic [31:0] stop_timeout_us;
        logic [31:0] slow_timeout_us;
    } spc_cfg_t;

    function automatic logic [1:0] state_code(input state_t st);
        logic [1:0] code;
        begin
            unique case (st)
                ST_RUN:   code = MS_CODE_RUN;
                ST_EMPTY: code = MS_CODE_EMPTY;
                ST_STOP:  code = MS_CODE_STOP;
                default:  code = MS_CODE_RUN;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/spc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// spc_cfg_regs
// APB register file: empty threshold, stop timeout, slow-rotation timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_cfg_regs
    import spc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output spc_cfg_t                   cfg
);

    logic [7:0]  empty_threshold_reg;
    logic [31:0] stop_timeout_reg;
    logic [31:0] slow_timeout_reg;
    logic [1:0]  reg_index;
    logic        wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_threshold_reg <= EMPTY_THRESHOLD_RST;
            stop_timeout_reg    <= STOP_TIMEOUT_RST;
            slow_timeout_reg    <= SLOW_TIMEOUT_RST;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_EMPTY_THRESHOLD: empty_threshold_reg <= pwdata[7:0];
                REG_STOP_TIMEOUT:    stop_timeout_reg    <= pwdata;
                REG_SLOW_TIMEOUT:    slow_timeout_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_EMPTY_THRESHOLD: prdata = {24'd0, empty_threshold_reg};
            REG_STOP_TIMEOUT:    prdata = stop_timeout_reg;
            REG_SLOW_TIMEOUT:    prdata = slow_timeout_reg;
            default:             prdata = '0;
        endcase
    end

    assign cfg.empty_threshold = empty_threshold_reg;
    assign cfg.stop_timeout_us = stop_timeout_reg;
    assign cfg.slow_timeout_us = slow_timeout_reg;

endmodule

`default_nettype wire

/* hw/rtl/spc_engine.sv */
// ----------------------------------------------------------------------------
// spc_engine
// Period latch, pulse counter and run/empty/stop state machine. Applies
// one event per enabled cycle and presents the post-event result.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_engine
    import spc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step_en,
    input  spc_in_t       item,
    input  spc_cfg_t      cfg,
    output spc_out_t      result
);

    logic [7:0]  pc_now_reg,       pc_now_next;
    logic [1:0]  edges_now_reg,    edges_now_next;   // [0] first pulse, [1] second
    logic [7:0]  pc_last_reg,      pc_last_next;
    logic [1:0]  edges_last_reg,   edges_last_next;
    logic        period_ready_reg, period_ready_next;
    logic [31:0] last_tooth_reg,   last_tooth_next;
    state_t      state_now_reg,    state_now_next;
    state_t      state_before_reg, state_before_next;
    logic        resync_reg,       resync_next;
    logic [31:0] sheet_total_reg,  sheet_total_next;

    logic [31:0] elapsed;
    logic        cnt_above;
    logic        cnt_equal;
    logic        cls_hit;
    logic        cls_sheet;
    logic        do_cls;
    state_t      cls_tag;

    assign elapsed   = item.time_us - last_tooth_reg;
    assign cnt_above = pc_last_reg > cfg.empty_threshold;
    assign cnt_equal = pc_last_reg == cfg.empty_threshold;
    assign cls_hit   = period_ready_reg && (cnt_above || cnt_equal);
    // equal count is a sheet only when the edges read 1 then 0
    assign cls_sheet = period_ready_reg &&
                       (cnt_above || (cnt_equal && edges_last_reg == 2'b01));

    always_comb begin
        pc_now_next       = pc_now_reg;
        edges_now_next    = edges_now_reg;
        pc_last_next      = pc_last_reg;
        edges_last_next   = edges_last_reg;
        period_ready_next = period_ready_reg;
        last_tooth_next   = last_tooth_reg;
        state_now_next    = state_now_reg;
        state_before_next = state_before_reg;
        resync_next       = resync_reg;
        sheet_total_next  = sheet_total_reg;
        do_cls            = 1'b0;
        cls_tag           = ST_STOP;

        unique case (item.opcode)
            OP_TOOTH: begin
                period_ready_next = 1'b1;
                pc_last_next      = pc_now_reg;
                pc_now_next       = '0;
                edges_last_next   = edges_now_reg;
                edges_now_next    = '0;
                last_tooth_next   = item.time_us;
            end
            OP_PULSE: begin
                if (pc_now_reg != PULSE_MAX) begin
                    pc_now_next = pc_now_reg + 8'd1;
                    if (pc_now_reg == 8'd0) begin
                        edges_now_next[0] = item.edge_level;
                    end else if (pc_now_reg == 8'd1) begin
                        edges_now_next[1] = item.edge_level;
                    end
                end
            end
            OP_EVAL: begin
                unique case (state_now_reg)
                    ST_RUN, ST_EMPTY: begin
                        do_cls  = 1'b1;
                        cls_tag = state_now_reg;
                    end
                    ST_STOP: begin
                        if (state_before_reg == ST_EMPTY) begin
                            if (elapsed > cfg.slow_timeout_us) begin
                                period_ready_next = 1'b0;
                                pc_now_next       = '0;
                                pc_last_next      = '0;
                                edges_last_next   = '0;
                            end else if (resync_reg) begin
                                if (pc_now_reg == cfg.empty_threshold) begin
                                    period_ready_next = 1'b0;
                                    pc_now_next       = '0;
                                    pc_last_next      = '0;
                                    edges_last_next   = '0;
                                    resync_next       = 1'b0;
                                end
                            end else begin
                                do_cls = 1'b1;
                                if (cls_hit) begin
                                    resync_next = 1'b1;
                                end
                            end
                        end else begin
                            do_cls = 1'b1;
                        end
                    end
                    default: ;
                endcase

                if (do_cls && period_ready_reg) begin
                    period_ready_next = 1'b0;
                    if (cls_hit) begin
                        state_before_next = cls_tag;
                        state_now_next    = cls_sheet ? ST_RUN : ST_EMPTY;
                        pc_last_next      = '0;
                        edges_last_next   = '0;
                        if (cls_sheet) begin
                            sheet_total_next = sheet_total_reg + 32'd1;
                        end
                    end
                end

                // timeout in run or empty overrides the classification
                if ((state_now_reg == ST_RUN || state_now_reg == ST_EMPTY) &&
                    elapsed > cfg.stop_timeout_us) begin
                    state_before_next = state_now_reg;
                    state_now_next    = ST_STOP;
                end
            end
            OP_CLEAR: begin
                sheet_total_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_now_reg       <= '0;
            edges_now_reg    <= '0;
            pc_last_reg      <= '0;
            edges_last_reg   <= '0;
            period_ready_reg <= 1'b0;
            last_tooth_reg   <= '0;
            state_now_reg    <= ST_RUN;
            state_before_reg <= ST_RUN;
            resync_reg       <= 1'b1;
            sheet_total_reg  <= '0;
        end else if (step_en) begin
            pc_now_reg       <= pc_now_next;
            edges_now_reg    <= edges_now_next;
            pc_last_reg      <= pc_last_next;
            edges_last_reg   <= edges_last_next;
            period_ready_reg <= period_ready_next;
            last_tooth_reg   <= last_tooth_next;
            state_now_reg    <= state_now_next;
            state_before_reg <= state_before_next;
            resync_reg       <= resync_next;
            sheet_total_reg  <= sheet_total_next;
        end
    end

    assign result.sheet_count   = sheet_total_next;
    assign result.machine_state = state_code(state_now_next);

endmodule

`default_nettype wire

/* hw/rtl/sheet_pulse_counter_fsm_core.sv */
// ----------------------------------------------------------------------------
// sheet_pulse_counter_fsm_core
// Sheet counter top level: input register, event engine, result register
// and APB configuration registers.
// ----------------------------------------------------------------------------
//  Channel   Ports               Moves
//  input     s_valid/s_ready     spc_in_t  (opcode, edge_level, time_us)
//  result    m_valid/m_ready     spc_out_t (sheet_count, machine_state)
//  config    APB psel..pready    8-, 32- and 32-bit registers at 0x0, 0x4, 0x8
//
//  An accepted input passes the input register, the engine and the result
//  register, which raises m_valid; one event is taken per cycle while the
//  result is not stalled, bounded by the single-pass engine between the two
//  registers. Synchronous active-low reset; no clearing pass. A stalled
//  result holds the engine; the input register still takes one more item.
// ----------------------------------------------------------------------------
`default_nettype none

module sheet_pulse_counter_fsm_core
    import spc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  spc_in_t                    s_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output spc_out_t                   m_data,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    spc_cfg_t cfg;
    spc_in_t  in_data_reg;
    logic     in_valid_reg;
    spc_out_t out_data_reg;
    logic     out_valid_reg;
    spc_out_t result;
    logic     fire;

    spc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // engine steps when an item is held and the result slot frees up
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    spc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (fire),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTH
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("engine step did not produce a result");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled while a slot was free");

    a_input_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted input transfer was lost");

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_data_reg.opcode == OP_CLEAR) |=> (m_data.sheet_count == 32'd0))
        else $error("clear did not zero the sheet count");
`endif

endmodule

`default_nettype wire

/* sim/spc_result_checker.sv */
// ----------------------------------------------------------------------------
// spc_result_checker
// Watches the event, result and APB channels of the sheet pulse counter,
// keeps its own copy of the counter state machine, and compares every
// result transfer with the oldest predicted report.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_result_checker
    import spc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  spc_in_t                    s_data,

    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  spc_out_t                   m_data,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic                  pready,

    output int                         fault_count,
    output int                         reports_due
);

    localparam int REPORT_LIMIT = 10;

    // configuration copy
    logic [7:0]  thr;
    logic [31:0] stop_lim;
    logic [31:0] slow_lim;

    // counter state copy
    logic [7:0]  cnt_open;
    logic [1:0]  lvl_open;      // [0] first pulse, [1] second pulse
    logic [7:0]  cnt_closed;
    logic [1:0]  lvl_closed;
    logic        closed_valid;
    logic [31:0] tooth_stamp;
    logic [1:0]  fsm_now;
    logic [1:0]  fsm_prev;
    logic        resync_armed;
    logic [31:0] sheets;

    spc_out_t pending_reports[$];

    task automatic clear_counter_state();
        thr          = EMPTY_THRESHOLD_RST;
        stop_lim     = STOP_TIMEOUT_RST;
        slow_lim     = SLOW_TIMEOUT_RST;
        cnt_open     = '0;
        lvl_open     = '0;
        cnt_closed   = '0;
        lvl_closed   = '0;
        closed_valid = 1'b0;
        tooth_stamp  = '0;
        fsm_now      = MS_CODE_RUN;
        fsm_prev     = MS_CODE_RUN;
        resync_armed = 1'b1;
        sheets       = '0;
    endtask

    task automatic discard_period();
        closed_valid = 1'b0;
        cnt_open     = '0;
        cnt_closed   = '0;
        lvl_closed   = '0;
    endtask

    // Classify the closed period; hit is set when it reached the threshold.
    task automatic grade_period(input logic [1:0] tag, output logic hit);
        hit = 1'b0;
        if (closed_valid) begin
            closed_valid = 1'b0;
            if (cnt_closed > thr) begin
                sheets   = sheets + 32'd1;
                fsm_prev = tag;
                fsm_now  = MS_CODE_RUN;
                hit      = 1'b1;
            end else if (cnt_closed == thr) begin
                fsm_prev = tag;
                if (lvl_closed[0] && !lvl_closed[1]) begin
                    sheets  = sheets + 32'd1;
                    fsm_now = MS_CODE_RUN;
                end else begin
                    fsm_now = MS_CODE_EMPTY;
                end
                hit = 1'b1;
            end
            if (hit) begin
                cnt_closed = '0;
                lvl_closed = '0;
            end
        end
    endtask

    task automatic advance_sheet_fsm(input spc_in_t ev, output spc_out_t rep);
        logic [31:0] elapsed;
        logic [1:0]  tag;
        logic        hit;
        elapsed = ev.time_us - tooth_stamp;
        case (ev.opcode)
            OP_TOOTH: begin
                closed_valid = 1'b1;
                cnt_closed   = cnt_open;
                lvl_closed   = lvl_open;
                cnt_open     = '0;
                lvl_open     = '0;
                tooth_stamp  = ev.time_us;
            end
            OP_PULSE: begin
                if (cnt_open != PULSE_MAX) begin
                    cnt_open = cnt_open + 8'd1;
                    if (cnt_open == 8'd1)
                        lvl_open[0] = ev.edge_level;
                    else if (cnt_open == 8'd2)
                        lvl_open[1] = ev.edge_level;
                end
            end
            OP_EVAL: begin
                if (fsm_now == MS_CODE_RUN || fsm_now == MS_CODE_EMPTY) begin
                    tag = fsm_now;
                    grade_period(tag, hit);
                    if (elapsed > stop_lim) begin
                        fsm_prev = tag;
                        fsm_now  = MS_CODE_STOP;
                    end
                end else if (fsm_now == MS_CODE_STOP) begin
                    if (fsm_prev == MS_CODE_RUN || fsm_prev == MS_CODE_STOP) begin
                        grade_period(MS_CODE_STOP, hit);
                    end else if (fsm_prev == MS_CODE_EMPTY) begin
                        if (elapsed > slow_lim) begin
                            discard_period();
                        end else if (resync_armed) begin
                            if (cnt_open == thr) begin
                                discard_period();
                                resync_armed = 1'b0;
                            end
                        end else begin
                            grade_period(MS_CODE_STOP, hit);
                            if (hit)
                                resync_armed = 1'b1;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                sheets = '0;
            end
        endcase
        rep.sheet_count   = sheets;
        rep.machine_state = fsm_now;
    endtask

    task automatic note_fault(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("result_checker: %s mismatch, expected 0x%08h, actual 0x%08h",
                     what, want, got);
    endtask

    always @(posedge aclk) begin
        spc_out_t rep;
        spc_out_t want;
        if (!aresetn) begin
            clear_counter_state();
            pending_reports.delete();
            fault_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_EMPTY_THRESHOLD: thr      = pwdata[7:0];
                    REG_STOP_TIMEOUT:    stop_lim = pwdata;
                    REG_SLOW_TIMEOUT:    slow_lim = pwdata;
                    default: ;
                endcase
            end
            // compare before queuing this edge's event: it cannot be answered yet
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("result_checker: result transfer with nothing expected");
                end else begin
                    want = pending_reports.pop_front();
                    if (m_data.sheet_count !== want.sheet_count)
                        note_fault("sheet_count", want.sheet_count, m_data.sheet_count);
                    if (m_data.machine_state !== want.machine_state)
                        note_fault("machine_state", {30'd0, want.machine_state},
                                   {30'd0, m_data.machine_state});
                end
            end
            if (s_valid && s_ready) begin
                advance_sheet_fsm(s_data, rep);
                pending_reports.push_back(rep);
            end
        end
        reports_due = pending_reports.size();
    end

endmodule

`default_nettype wire

/* sim/tb_sheet_pulse_counter_fsm_core.sv */
// ----------------------------------------------------------------------------
// tb_sheet_pulse_counter_fsm_core
// Drives tooth, pulse, evaluate and clear events into the sheet counter
// under several threshold and timeout settings, with bursty input and a
// stalling result sink; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sheet_pulse_counter_fsm_core;
    import spc_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 80;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    spc_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    spc_out_t              m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fault_count;
    int reports_due;

    bit          hold_pending = 1'b0;
    int          burst_left   = 0;
    int          items_sent   = 0;
    logic [7:0]  thr_cfg;
    logic [31:0] stop_cfg;
    logic [31:0] slow_cfg;
    logic [31:0] tooth_t;

    sheet_pulse_counter_fsm_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    spc_result_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fault_count (fault_count),
        .reports_due (reports_due)
    );

    initial aclk = 1'b0;
    always #(HALF_PERIOD) aclk = ~aclk;

    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("tb_sheet_pulse_counter_fsm_core: FAIL");
        $finish;
    end

    // Result sink: random stall segments, plus one long hold on request.
    initial begin
        int seg_left;
        int mode;
        seg_left = 0;
        mode     = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(4, 40);
                end
                seg_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // One event transfer; the sender may idle between bursts of random length.
    task automatic send_item(input logic [1:0] op, input logic lvl, input logic [31:0] t);
        int      gap;
        spc_in_t ev;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        ev.opcode     = op;
        ev.edge_level = lvl;
        ev.time_us    = t;
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_TOOTH)
            tooth_t = t;
        items_sent++;
    endtask

    task automatic send_pulses(input int n, input bit one_then_zero);
        logic lvl;
        for (int k = 0; k < n; k++) begin
            if (one_then_zero && k < 2)
                lvl = (k == 0);
            else
                lvl = 1'($urandom_range(0, 1));
            send_item(OP_PULSE, lvl, $urandom);
        end
    endtask

    function automatic logic [31:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 3);
            1:       return stop_cfg;
            2:       return stop_cfg + 32'd1;
            3:       return slow_cfg;
            4:       return slow_cfg + 32'd1;
            5:       return $urandom;
            default: return $urandom_range(0, 50);
        endcase
    endfunction

    function automatic int pick_count();
        int base;
        base = int'(thr_cfg);
        // long periods are costly; keep most of them short at high thresholds
        if (base > 16 && $urandom_range(0, 3) != 0)
            return $urandom_range(0, 4);
        case ($urandom_range(0, 5))
            0:       return (base == 0) ? 0 : base - 1;
            1, 2:    return base;
            3:       return base + 1;
            4:       return $urandom_range(0, 4);
            default: return base + $urandom_range(2, 6);
        endcase
    endfunction

    task automatic send_tooth();
        logic [31:0] t;
        if ($urandom_range(0, 7) == 0)
            t = $urandom;
        else
            t = tooth_t + $urandom_range(1, 200);
        send_item(OP_TOOTH, 1'($urandom_range(0, 1)), t);
    endtask

    task automatic send_eval();
        send_item(OP_EVAL, 1'($urandom_range(0, 1)), tooth_t + pick_elapsed());
    endtask

    task automatic random_episode();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        n    = pick_count();
        if (kind <= 4) begin
            send_pulses(n, 1'($urandom_range(0, 1)));
            send_tooth();
            send_eval();
            if ($urandom_range(0, 2) == 0)
                send_eval();
        end else if (kind <= 6) begin
            // pulses with no tooth: exercises the resync discard
            send_pulses(n, 1'($urandom_range(0, 1)));
            send_eval();
        end else if (kind == 7) begin
            send_eval();
        end else if (kind == 8) begin
            send_item(OP_CLEAR, 1'($urandom_range(0, 1)), $urandom);
        end else begin
            repeat ($urandom_range(1, 3))
                send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
        end
    endtask

    task automatic run_random(input int budget);
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
            random_episode();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (reports_due != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_limits(input logic [7:0] thr, input logic [31:0] stop_us,
                              input logic [31:0] slow_us);
        wait_drained();
        repeat (3) @(posedge aclk);
        apb_write(REG_EMPTY_THRESHOLD, {24'd0, thr});
        apb_write(REG_STOP_TIMEOUT, stop_us);
        apb_write(REG_SLOW_TIMEOUT, slow_us);
        thr_cfg  = thr;
        stop_cfg = stop_us;
        slow_cfg = slow_us;
    endtask

    // Walks every branch at reset settings (threshold 2, 1 s / 1.5 s).
    task automatic run_directed();
        send_item(OP_EVAL, 1'b0, 32'd0);
        // above threshold
        send_pulses(3, 1'b1);
        send_item(OP_TOOTH, 1'b0, 32'd100);
        send_item(OP_EVAL, 1'b0, 32'd150);
        // at threshold, edges 1 then 0
        send_pulses(2, 1'b1);
        send_item(OP_TOOTH, 1'b0, 32'd300);
        send_item(OP_EVAL, 1'b1, 32'd301);
        // at threshold, edges 0 then 1: empty
        send_item(OP_PULSE, 1'b0, 32'd0);
        send_item(OP_PULSE, 1'b1, 32'd0);
        send_item(OP_TOOTH, 1'b0, 32'd500);
        send_item(OP_EVAL, 1'b0, 32'd600);
        // timeout from empty, then resync discard on an open period
        send_item(OP_EVAL, 1'b0, 32'd1000501);
        send_pulses(2, 1'b0);
        send_item(OP_EVAL, 1'b0, 32'd1000600);
        // stop after empty, resync done: classified, resync rearmed
        send_pulses(3, 1'b1);
        send_item(OP_TOOTH, 1'b0, 32'd1001000);
        send_item(OP_EVAL, 1'b0, 32'd1001001);
        send_item(OP_CLEAR, 1'b1, 32'hFFFF_FFFF);
        // timeout from run
        send_item(OP_EVAL, 1'b0, 32'd2001001);
        // time wraps between tooth and evaluate; edges 1,1 give empty
        send_item(OP_PULSE, 1'b1, 32'd0);
        send_item(OP_PULSE, 1'b1, 32'd0);
        send_item(OP_TOOTH, 1'b1, 32'hFFFF_FF00);
        send_item(OP_EVAL, 1'b0, 32'h0000_0010);
        // timeout from empty, then slow rotation discard
        send_item(OP_EVAL, 1'b0, 32'hFFFF_FF00 + 32'd1000001);
        send_item(OP_EVAL, 1'b0, 32'hFFFF_FF00 + 32'd1500001);
    endtask

    initial begin
        thr_cfg  = EMPTY_THRESHOLD_RST;
        stop_cfg = STOP_TIMEOUT_RST;
        slow_cfg = SLOW_TIMEOUT_RST;
        tooth_t  = '0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        set_limits(8'd2, 32'd1000, 32'd1500);
        run_random(90);

        set_limits(8'd0, 32'd0, 32'hFFFF_FFFF);
        run_random(70);

        // counter saturates at 255, the threshold here: 260 pulses still match 255
        set_limits(8'd255, 32'hFFFF_FFFF, 32'd0);
        send_pulses(260, 1'b1);
        send_tooth();
        send_eval();
        run_random(40);

        // long result hold while input keeps coming, then a full drain
        set_limits(8'd1, 32'd300, 32'd600);
        hold_pending = 1'b1;
        run_random(50);
        wait_drained();
        run_random(50);

        set_limits(8'($urandom_range(1, 6)), $urandom_range(0, 3000),
                   $urandom_range(3000, 6000));
        run_random(70);

        set_limits(EMPTY_THRESHOLD_RST, STOP_TIMEOUT_RST, SLOW_TIMEOUT_RST);
        run_random(60);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fault_count == 0 && reports_due == 0)
            $display("tb_sheet_pulse_counter_fsm_core: PASS");
        else
            $display("tb_sheet_pulse_counter_fsm_core: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
